@@ rtl/core/decimal_number_text_parser_defines.svh @@
// Assertion macros used by the checker file of the number parser.
`ifndef DECIMAL_NUMBER_TEXT_PARSER_DEFINES_SVH
`define DECIMAL_NUMBER_TEXT_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DNP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/dnp_pkg.sv @@
`default_nettype none

package dnp_pkg;

    localparam int CHAR_W      = 8;
    localparam int EXP_W       = 18;
    localparam int SIG_OUT_W   = 64;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 2;

    localparam int OFS_NEG  = 0;
    localparam int OFS_SIG  = OFS_NEG + 1;
    localparam int OFS_EXP  = OFS_SIG + SIG_OUT_W;
    localparam int OFS_STOP = OFS_EXP + EXP_W;
    localparam int OFS_PAD  = OFS_STOP + CHAR_W;

    localparam int USR_STATUS = 0;
    localparam int USR_SAT    = 1;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TOLERANT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEC_SEP  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_THOU_SEP = 2'd2;

    localparam logic [CHAR_W-1:0] DEC_SEP_RST  = 8'd46;
    localparam logic [CHAR_W-1:0] THOU_SEP_RST = 8'd44;

    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_E = 8'h45;
    localparam logic [CHAR_W-1:0] CH_LOWER_E = 8'h65;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic              tolerant;
        logic [CHAR_W-1:0] dec_sep;
        logic [CHAR_W-1:0] thou_sep;
    } t_cfg;

    typedef struct packed {
        logic              eot;
        logic [CHAR_W-1:0] code;
        logic              is_digit;
        logic [3:0]        digit;
        logic              is_minus;
        logic              is_plus;
        logic              is_dsep;
        logic              is_tsep;
        logic              is_eletter;
    } t_item;

endpackage

`default_nettype wire

@@ rtl/core/dnp_front.sv @@
`default_nettype none

module dnp_front (
    input  dnp_pkg::t_cfg               i_cfg,
    input  logic [dnp_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_eot,
    output dnp_pkg::t_item              o_item
);
    import dnp_pkg::*;

    logic [CHAR_W-1:0] w_offset;

    assign w_offset = i_char - CH_ZERO;

    always_comb begin
        o_item.eot        = i_eot;
        o_item.code       = i_char;
        o_item.is_digit   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        o_item.digit      = w_offset[3:0];
        o_item.is_minus   = (i_char == CH_MINUS);
        o_item.is_plus    = (i_char == CH_PLUS);
        o_item.is_dsep    = (i_char == i_cfg.dec_sep);
        o_item.is_tsep    = (i_char == i_cfg.thou_sep);
        o_item.is_eletter = (i_char == CH_UPPER_E) || (i_char == CH_LOWER_E);
    end

endmodule

`default_nettype wire

@@ rtl/core/dnp_queue.sv @@
`default_nettype none

module dnp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dnp_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    output dnp_pkg::t_item o_item,
    input  logic           i_pop
);
    import dnp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // The depth is a power of two, so the pointers wrap on their own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dnp_back.sv @@
`default_nettype none

module dnp_back #(
    parameter int SIGNIFICAND_BITS = 64,
    parameter int COUNT_BITS       = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dnp_pkg::t_cfg                      i_cfg,
    input  logic                               i_item_valid,
    input  dnp_pkg::t_item                     i_item,
    output logic                               o_item_pop,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [dnp_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic [dnp_pkg::OUT_TUSER_W-1:0]    o_m_tuser,
    output logic                               o_m_tlast
);
    import dnp_pkg::*;

    localparam int SB = SIGNIFICAND_BITS;
    localparam int CB = COUNT_BITS;
    localparam int SX = SB + 4;
    localparam int CX = CB + 4;

    typedef enum logic [2:0] {
        PH_START, PH_SIGNED, PH_INT, PH_FRAC_START, PH_FRAC,
        PH_EXP_START, PH_EXP_SIGN, PH_EXP
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic                   r_mant_neg, n_mant_neg;
    logic                   r_exp_neg, n_exp_neg;
    logic                   r_found_int, n_found_int;
    logic                   r_found_frac, n_found_frac;
    logic                   r_found_exp, n_found_exp;
    logic                   r_found_elet, n_found_elet;
    logic [SB-1:0]          r_sig, n_sig;
    logic [CB-1:0]          r_frac, n_frac;
    logic [CB-1:0]          r_exp, n_exp;
    logic                   r_sat, n_sat;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user, n_out_user;
    logic                   r_out_last;

    logic          w_consumed;
    logic          w_add_sig;
    logic          w_add_frac;
    logic          w_add_exp;
    logic [SX-1:0] w_sig_x10;
    logic [CX-1:0] w_exp_x10;
    logic          w_finish;
    logic          w_out_free;

    logic                 w_mant;
    logic                 w_res_neg;
    logic [SIG_OUT_W-1:0] w_res_sig;
    logic [EXP_W-1:0]     w_res_exp;
    logic                 w_res_status;
    logic [EXP_W-1:0]     w_e_ext;
    logic [EXP_W-1:0]     w_e_val;
    logic [EXP_W-1:0]     w_f_ext;

    assign w_sig_x10 = {1'b0, r_sig, 3'b000} + {3'b000, r_sig, 1'b0} + SX'(i_item.digit);
    assign w_exp_x10 = {1'b0, r_exp, 3'b000} + {3'b000, r_exp, 1'b0} + CX'(i_item.digit);

    always_comb begin
        n_phase      = r_phase;
        n_mant_neg   = r_mant_neg;
        n_exp_neg    = r_exp_neg;
        n_found_int  = r_found_int;
        n_found_frac = r_found_frac;
        n_found_exp  = r_found_exp;
        n_found_elet = r_found_elet;
        n_sig        = r_sig;
        n_frac       = r_frac;
        n_exp        = r_exp;
        n_sat        = r_sat;
        w_consumed   = 1'b0;
        w_add_sig    = 1'b0;
        w_add_frac   = 1'b0;
        w_add_exp    = 1'b0;

        case (r_phase)
            PH_START, PH_SIGNED: begin
                w_consumed = 1'b1;
                if ((r_phase == PH_START) && i_item.is_minus) begin
                    n_mant_neg = 1'b1;
                    n_phase    = PH_SIGNED;
                end else if ((r_phase == PH_START) && i_item.is_plus) begin
                    n_phase = PH_SIGNED;
                end else if (i_item.is_digit) begin
                    n_found_int = 1'b1;
                    w_add_sig   = 1'b1;
                    n_phase     = PH_INT;
                end else if (i_item.is_dsep) begin
                    n_phase = PH_FRAC_START;
                end else if (i_item.is_eletter) begin
                    n_found_elet = 1'b1;
                    n_phase      = PH_EXP_START;
                end else begin
                    w_consumed = 1'b0;
                end
            end
            PH_INT: begin
                w_consumed = 1'b1;
                if (i_item.is_tsep) begin
                    n_phase = PH_INT;
                end else if (i_item.is_digit) begin
                    w_add_sig = 1'b1;
                end else if (i_item.is_dsep) begin
                    n_phase = PH_FRAC_START;
                end else if (i_item.is_eletter) begin
                    n_found_elet = 1'b1;
                    n_phase      = PH_EXP_START;
                end else begin
                    w_consumed = 1'b0;
                end
            end
            PH_FRAC_START, PH_FRAC: begin
                w_consumed = 1'b1;
                if (i_item.is_digit) begin
                    n_found_frac = 1'b1;
                    w_add_sig    = 1'b1;
                    w_add_frac   = 1'b1;
                    n_phase      = PH_FRAC;
                end else if (i_item.is_eletter) begin
                    n_found_elet = 1'b1;
                    n_phase      = PH_EXP_START;
                end else begin
                    w_consumed = 1'b0;
                end
            end
            PH_EXP_START, PH_EXP_SIGN, PH_EXP: begin
                w_consumed = 1'b1;
                if ((r_phase == PH_EXP_START) && i_item.is_minus) begin
                    n_exp_neg = 1'b1;
                    n_phase   = PH_EXP_SIGN;
                end else if ((r_phase == PH_EXP_START) && i_item.is_plus) begin
                    n_phase = PH_EXP_SIGN;
                end else if (i_item.is_digit) begin
                    n_found_exp = 1'b1;
                    w_add_exp   = 1'b1;
                    n_phase     = PH_EXP;
                end else begin
                    w_consumed = 1'b0;
                end
            end
            default: begin
                w_consumed = 1'b0;
            end
        endcase

        if (w_add_sig) begin
            if (|w_sig_x10[SX-1:SB]) begin
                n_sig = '1;
                n_sat = 1'b1;
            end else begin
                n_sig = w_sig_x10[SB-1:0];
            end
        end
        if (w_add_frac) begin
            if (&r_frac) begin
                n_sat = 1'b1;
            end else begin
                n_frac = r_frac + 1'b1;
            end
        end
        if (w_add_exp) begin
            if (|w_exp_x10[CX-1:CB]) begin
                n_exp = '1;
                n_sat = 1'b1;
            end else begin
                n_exp = w_exp_x10[CB-1:0];
            end
        end
    end

    assign w_e_ext = EXP_W'(r_exp);
    assign w_e_val = r_exp_neg ? (~w_e_ext + 1'b1) : w_e_ext;
    assign w_f_ext = EXP_W'(r_frac);
    assign w_mant  = r_found_int || r_found_frac;

    always_comb begin
        w_res_neg    = 1'b0;
        w_res_sig    = '0;
        w_res_exp    = '0;
        w_res_status = 1'b0;
        if (w_mant) begin
            if (r_found_exp) begin
                w_res_neg = r_mant_neg;
                w_res_sig = SIG_OUT_W'(r_sig);
                w_res_exp = w_e_val - w_f_ext;
            end else if (r_found_elet && !i_cfg.tolerant) begin
                w_res_status = 1'b1;
            end else begin
                w_res_neg = r_mant_neg;
                w_res_sig = SIG_OUT_W'(r_sig);
                w_res_exp = EXP_W'(0) - w_f_ext;
            end
        end else if (r_found_exp) begin
            w_res_neg = r_mant_neg;
            w_res_sig = SIG_OUT_W'(1);
            w_res_exp = w_e_val;
        end else if (!i_cfg.tolerant) begin
            w_res_status = 1'b1;
        end else begin
            w_res_sig = SIG_OUT_W'(r_found_elet);
        end

        n_out_data                          = '0;
        n_out_data[OFS_NEG]                 = w_res_neg;
        n_out_data[OFS_SIG +: SIG_OUT_W]    = w_res_sig;
        n_out_data[OFS_EXP +: EXP_W]        = w_res_exp;
        n_out_data[OFS_STOP +: CHAR_W]      = i_item.eot ? '0 : i_item.code;
        n_out_user                          = '0;
        n_out_user[USR_STATUS]              = w_res_status;
        n_out_user[USR_SAT]                 = r_sat;
    end

    assign w_finish   = i_item.eot || !w_consumed;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_item_pop = i_item_valid && (!w_finish || w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_mant_neg   <= 1'b0;
            r_exp_neg    <= 1'b0;
            r_found_int  <= 1'b0;
            r_found_frac <= 1'b0;
            r_found_exp  <= 1'b0;
            r_found_elet <= 1'b0;
            r_sig        <= '0;
            r_frac       <= '0;
            r_exp        <= '0;
            r_sat        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_item_pop && w_finish) begin
                r_phase      <= PH_START;
                r_mant_neg   <= 1'b0;
                r_exp_neg    <= 1'b0;
                r_found_int  <= 1'b0;
                r_found_frac <= 1'b0;
                r_found_exp  <= 1'b0;
                r_found_elet <= 1'b0;
                r_sig        <= '0;
                r_frac       <= '0;
                r_exp        <= '0;
                r_sat        <= 1'b0;
                r_out_valid  <= 1'b1;
                r_out_data   <= n_out_data;
                r_out_user   <= n_out_user;
                r_out_last   <= i_item.eot;
            end else begin
                if (o_item_pop) begin
                    r_phase      <= n_phase;
                    r_mant_neg   <= n_mant_neg;
                    r_exp_neg    <= n_exp_neg;
                    r_found_int  <= n_found_int;
                    r_found_frac <= n_found_frac;
                    r_found_exp  <= n_found_exp;
                    r_found_elet <= n_found_elet;
                    r_sig        <= n_sig;
                    r_frac       <= n_frac;
                    r_exp        <= n_exp;
                    r_sat        <= n_sat;
                end
                if (i_m_tready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/core/decimal_number_text_parser.sv @@
// Throughput: one character per clock cycle, sustained while the result side takes requests.
// The character ending the literal passes through the queue stage, and its result is presented
// on the output from the output register.
// Reset (synchronous, active low) clears the parse state, the queue and the output valid,
// and returns the configuration registers to their reset values; no clearing pass is needed.
`default_nettype none

module decimal_number_text_parser #(
    parameter int SIGNIFICAND_BITS = 64,
    parameter int COUNT_BITS       = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [dnp_pkg::CHAR_W-1:0]         i_s_tdata,  // [7:0] char_code
    input  logic                               i_s_tlast,  // end_of_text
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] is_negative, [64:1] significand, [82:65] exponent_ten,
    // [90:83] stop_char, [95:91] zero
    output logic [dnp_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic [dnp_pkg::OUT_TUSER_W-1:0]    o_m_tuser,  // [0] status, [1] saturated
    output logic                               o_m_tlast,  // stopped_at_end
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [dnp_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [dnp_pkg::APB_DATA_W-1:0]     i_pwdata,
    output logic [dnp_pkg::APB_DATA_W-1:0]     o_prdata,
    output logic                               o_pready
);
    import dnp_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_cfg_write;
    t_item                w_front_item;
    t_item                w_queue_item;
    logic                 w_queue_valid;
    logic                 w_queue_pop;
    logic                 w_push;

    assign o_pready    = 1'b1;
    assign w_reg_idx   = i_paddr[APB_ADDR_W-1:2];
    assign w_cfg_write = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerant <= 1'b0;
            r_cfg.dec_sep  <= DEC_SEP_RST;
            r_cfg.thou_sep <= THOU_SEP_RST;
        end else if (w_cfg_write) begin
            case (w_reg_idx)
                REG_TOLERANT: r_cfg.tolerant <= i_pwdata[0];
                REG_DEC_SEP:  r_cfg.dec_sep  <= i_pwdata[CHAR_W-1:0];
                REG_THOU_SEP: r_cfg.thou_sep <= i_pwdata[CHAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_TOLERANT: o_prdata = APB_DATA_W'(r_cfg.tolerant);
            REG_DEC_SEP:  o_prdata = APB_DATA_W'(r_cfg.dec_sep);
            REG_THOU_SEP: o_prdata = APB_DATA_W'(r_cfg.thou_sep);
            default:      o_prdata = '0;
        endcase
    end

    dnp_front u_front (
        .i_cfg  (r_cfg),
        .i_char (i_s_tdata),
        .i_eot  (i_s_tlast),
        .o_item (w_front_item)
    );

    assign w_push = i_s_tvalid && o_s_tready;

    dnp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (o_s_tready),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item),
        .i_pop   (w_queue_pop)
    );

    dnp_back #(
        .SIGNIFICAND_BITS (SIGNIFICAND_BITS),
        .COUNT_BITS       (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_queue_valid),
        .i_item       (w_queue_item),
        .o_item_pop   (w_queue_pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/dnp_checker.sv @@
`default_nettype none
`include "decimal_number_text_parser_defines.svh"

module dnp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [dnp_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input logic [dnp_pkg::OUT_TUSER_W-1:0] i_m_tuser,
    input logic                            i_m_tlast
);
    import dnp_pkg::*;

    // A stalled result request keeps its payload.
    `DNP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "result changed while stalled")

    // An invalid literal carries no sign, significand or exponent.
    `DNP_ASSERT_SAME(a_invalid_zero, i_clk, i_rst_n, i_m_tvalid && i_m_tuser[USR_STATUS], i_m_tdata[OFS_STOP-1:0] == '0, "invalid result with non-zero value")

    // A literal ended by the end of text reports no stop character.
    `DNP_ASSERT_SAME(a_end_stop_zero, i_clk, i_rst_n, i_m_tvalid && i_m_tlast, i_m_tdata[OFS_STOP +: CHAR_W] == '0, "stop character set at end of text")

    // The padding bits of the result stay clear.
    `DNP_ASSERT_SAME(a_pad_zero, i_clk, i_rst_n, i_m_tvalid, i_m_tdata[OUT_TDATA_W-1:OFS_PAD] == '0, "padding bits set")

endmodule

bind decimal_number_text_parser dnp_checker u_dnp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

`default_nettype wire

@@ tb/decimal_number_text_parser_test.sv @@
`timescale 1ns / 100ps

module decimal_number_text_parser_test;

    import dnp_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 5000;
    localparam logic [63:0] SIG_MAX = '1;
    localparam int CNT_MAX = 65535;

    typedef enum logic [3:0] {
        PH_START,
        PH_SIGNED,
        PH_INT,
        PH_FRAC_START,
        PH_FRAC,
        PH_EXP_START,
        PH_EXP_SIGN,
        PH_EXP
    } parse_phase_e;

    typedef struct packed {
        logic        neg;
        logic [63:0] sig;
        logic [17:0] exp10;
        logic        status;
        logic        sat;
        logic [7:0]  stop;
        logic        at_end;
    } number_t;

    logic                  i_clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  o_s_tready;
    logic [CHAR_W-1:0]     s_tdata;
    logic                  s_tlast;
    logic                  o_m_tvalid;
    logic                  m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;
    logic                  o_m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    // Parser model state and its copy of the registers.
    logic         cfg_tolerant;
    logic [7:0]   cfg_dec_sep;
    logic [7:0]   cfg_thou_sep;
    parse_phase_e parse_state;
    logic         mant_negative;
    logic         exp_negative;
    logic         found_int;
    logic         found_frac;
    logic         found_exp;
    logic         found_eletter;
    logic [63:0]  sig_acc;
    int           frac_count;
    int           exp_acc;
    logic         sat_flag;

    number_t pending_numbers[$];
    int      error_count;
    int      chars_sent;
    int      quiet_cycles;
    bit      tx_gap_on;
    bit      rx_stall_on;
    bit      hold_off_req;

    decimal_number_text_parser u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_literal();
        parse_state   = PH_START;
        mant_negative = 1'b0;
        exp_negative  = 1'b0;
        found_int     = 1'b0;
        found_frac    = 1'b0;
        found_exp     = 1'b0;
        found_eletter = 1'b0;
        sig_acc       = '0;
        frac_count    = 0;
        exp_acc       = 0;
        sat_flag      = 1'b0;
    endfunction

    function automatic void add_sig_digit(input logic [3:0] d);
        if (sig_acc > (SIG_MAX - 64'(d)) / 64'd10) begin
            sig_acc  = SIG_MAX;
            sat_flag = 1'b1;
        end else begin
            sig_acc = sig_acc * 64'd10 + 64'(d);
        end
    endfunction

    function automatic void add_exp_digit(input logic [3:0] d);
        if (exp_acc > (CNT_MAX - int'(d)) / 10) begin
            exp_acc  = CNT_MAX;
            sat_flag = 1'b1;
        end else begin
            exp_acc = exp_acc * 10 + int'(d);
        end
    endfunction

    function automatic bit sep_or_exp_letter(input logic [7:0] c, input bit allow_sep);
        if (allow_sep && c == cfg_dec_sep) begin
            parse_state = PH_FRAC_START;
            return 1'b1;
        end
        if (c == CH_UPPER_E || c == CH_LOWER_E) begin
            found_eletter = 1'b1;
            parse_state   = PH_EXP_START;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Returns 1 when the character continues the literal.
    function automatic bit take_char(input logic [7:0] c);
        bit dig;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        case (parse_state)
            PH_START, PH_SIGNED: begin
                if (parse_state == PH_START && c == CH_MINUS) begin
                    mant_negative = 1'b1;
                    parse_state   = PH_SIGNED;
                    return 1'b1;
                end
                if (parse_state == PH_START && c == CH_PLUS) begin
                    parse_state = PH_SIGNED;
                    return 1'b1;
                end
                if (dig) begin
                    found_int = 1'b1;
                    add_sig_digit(4'(c - CH_ZERO));
                    parse_state = PH_INT;
                    return 1'b1;
                end
                return sep_or_exp_letter(c, 1'b1);
            end
            PH_INT: begin
                if (c == cfg_thou_sep) return 1'b1;
                if (dig) begin
                    add_sig_digit(4'(c - CH_ZERO));
                    return 1'b1;
                end
                return sep_or_exp_letter(c, 1'b1);
            end
            PH_FRAC_START, PH_FRAC: begin
                if (dig) begin
                    found_frac = 1'b1;
                    add_sig_digit(4'(c - CH_ZERO));
                    if (frac_count >= CNT_MAX) sat_flag = 1'b1;
                    else frac_count++;
                    parse_state = PH_FRAC;
                    return 1'b1;
                end
                return sep_or_exp_letter(c, 1'b0);
            end
            PH_EXP_START, PH_EXP_SIGN, PH_EXP: begin
                if (parse_state == PH_EXP_START && c == CH_MINUS) begin
                    exp_negative = 1'b1;
                    parse_state  = PH_EXP_SIGN;
                    return 1'b1;
                end
                if (parse_state == PH_EXP_START && c == CH_PLUS) begin
                    parse_state = PH_EXP_SIGN;
                    return 1'b1;
                end
                if (dig) begin
                    found_exp = 1'b1;
                    add_exp_digit(4'(c - CH_ZERO));
                    parse_state = PH_EXP;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic number_t close_literal(input logic [7:0] stop, input logic at_end);
        number_t r;
        bit      mant;
        int      e;
        mant = found_int || found_frac;
        e = exp_negative ? -exp_acc : exp_acc;
        r = '0;
        if (mant) begin
            if (found_exp) begin
                r.neg   = mant_negative;
                r.sig   = sig_acc;
                r.exp10 = 18'(e - frac_count);
            end else if (found_eletter && !cfg_tolerant) begin
                r.status = 1'b1;
            end else begin
                r.neg   = mant_negative;
                r.sig   = sig_acc;
                r.exp10 = 18'(-frac_count);
            end
        end else if (found_exp) begin
            r.neg   = mant_negative;
            r.sig   = 64'd1;
            r.exp10 = 18'(e);
        end else if (!cfg_tolerant) begin
            r.status = 1'b1;
        end else begin
            r.sig = 64'(found_eletter);
        end
        r.sat    = sat_flag;
        r.stop   = stop;
        r.at_end = at_end;
        clear_literal();
        return r;
    endfunction

    function automatic void parse_char(input logic eot, input logic [7:0] c);
        if (eot) pending_numbers.push_back(close_literal(8'd0, 1'b1));
        else if (!take_char(c)) pending_numbers.push_back(close_literal(c, 1'b0));
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic send_char(input logic eot, input logic [7:0] c);
        int gap;
        gap = (tx_gap_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        do @(posedge i_clk); while (!o_s_tready);
        chars_sent++;
        parse_char(eot, c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(1'b0, s[i]);
    endtask

    task automatic send_end();
        send_char(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_digits(input int n, input bit grouped);
        for (int i = 0; i < n; i++) begin
            send_char(1'b0, 8'(CH_ZERO + $urandom_range(0, 9)));
            if (grouped && $urandom_range(0, 4) == 0) send_char(1'b0, cfg_thou_sep);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_numbers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TOLERANT: cfg_tolerant = value[0];
            REG_DEC_SEP:  cfg_dec_sep  = value;
            REG_THOU_SEP: cfg_thou_sep = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_random_literal();
        int n;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) send_char(1'b0, 8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 2))
            0: send_text("-");
            1: send_text("+");
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 2);
        else if ($urandom_range(0, 15) == 0) n = $urandom_range(18, 24);
        else n = $urandom_range(1, 6);
        send_digits(n, 1'b1);
        if ($urandom_range(0, 1) == 0) begin
            send_char(1'b0, cfg_dec_sep);
            send_digits($urandom_range(0, 5), 1'b0);
        end
        if ($urandom_range(0, 2) == 0) begin
            send_char(1'b0, $urandom_range(0, 1) ? CH_UPPER_E : CH_LOWER_E);
            case ($urandom_range(0, 2))
                0: send_text("-");
                1: send_text("+");
                default: ;
            endcase
            send_digits($urandom_range(0, 7) == 0 ? $urandom_range(4, 6) : $urandom_range(0, 3),
                        1'b0);
        end
        if ($urandom_range(0, 19) == 0) send_char(1'b0, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) send_end();
        else send_char(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_basic_literals();
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
        send_text("-1,2.5e-3 ");
        send_text("e5");
        send_end();
        send_text("1ex");
        send_char(1'b0, CH_PLUS);
        send_char(1'b0, 8'hFF);
        send_char(1'b0, 8'h00);
        send_end();
        send_text("9E+99999");
        send_end();
        settle();
    endtask

    task automatic test_significand_limit();
        send_text("18446744073709551615;");
        send_text("-18446744073709551616");
        send_end();
        settle();
    endtask

    task automatic test_tolerant_mode();
        write_reg(REG_TOLERANT, 8'd1);
        send_text("1e;-;E;-e-;.;+.5e;");
        send_end();
        settle();
        write_reg(REG_TOLERANT, 8'd0);
    endtask

    task automatic test_separator_codes();
        write_reg(REG_DEC_SEP, 8'h00);
        write_reg(REG_THOU_SEP, 8'hFF);
        send_text("1");
        send_char(1'b0, 8'hFF);
        send_text("2");
        send_char(1'b0, 8'h00);
        send_text("5");
        send_end();
        settle();
        write_reg(REG_DEC_SEP, DEC_SEP_RST);
        write_reg(REG_THOU_SEP, DEC_SEP_RST);
        send_text("1.2.3;.4.5;");
        settle();
        write_reg(REG_DEC_SEP, CH_LOWER_E);
        write_reg(REG_THOU_SEP, CH_ZERO + 8'd5);
        send_text("e5;15e5e2;");
        send_end();
        settle();
        write_reg(REG_DEC_SEP, DEC_SEP_RST);
        write_reg(REG_THOU_SEP, THOU_SEP_RST);
    endtask

    task automatic test_back_pressure();
        tx_gap_on    = 1'b0;
        hold_off_req = 1'b1;
        repeat (20) send_text("7 ");
        settle();
    endtask

    task automatic test_long_fraction();
        tx_gap_on = 1'b0;
        send_text("0.");
        repeat (30) send_char(1'b0, CH_ZERO + 8'd3);
        send_text("e-99999");
        send_end();
        settle();
    endtask

    task automatic test_random_text();
        string sep_pool = ".,' ;";
        int    target;
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_TOLERANT, 8'(p % 2));
            write_reg(REG_DEC_SEP, $urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255))
                                   : 8'(sep_pool[$urandom_range(0, 4)]));
            write_reg(REG_THOU_SEP, $urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255))
                                    : 8'(sep_pool[$urandom_range(0, 4)]));
            tx_gap_on   = (p != 0);
            rx_stall_on = (p != 0);
            target = chars_sent + 50;
            while (chars_sent < target) send_random_literal();
            send_end();
            settle();
        end
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
                stall_left = gap_length() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        number_t got;
        number_t want;
        if (rst_n && o_m_tvalid && m_tready) begin
            got.neg    = o_m_tdata[OFS_NEG];
            got.sig    = o_m_tdata[OFS_SIG +: SIG_OUT_W];
            got.exp10  = o_m_tdata[OFS_EXP +: EXP_W];
            got.stop   = o_m_tdata[OFS_STOP +: CHAR_W];
            got.status = o_m_tuser[USR_STATUS];
            got.sat    = o_m_tuser[USR_SAT];
            got.at_end = o_m_tlast;
            if (pending_numbers.size() == 0) begin
                $display("%0t: unexpected result request, expected none, actual %h",
                         $time, got);
                error_count++;
            end else begin
                want = pending_numbers.pop_front();
                check_field("is_negative", 64'(want.neg), 64'(got.neg));
                check_field("significand", want.sig, got.sig);
                check_field("exponent_ten", 64'(want.exp10), 64'(got.exp10));
                check_field("status", 64'(want.status), 64'(got.status));
                check_field("saturated", 64'(want.sat), 64'(got.sat));
                check_field("stop_char", 64'(want.stop), 64'(got.stop));
                check_field("stopped_at_end", 64'(want.at_end), 64'(got.at_end));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("decimal_number_text_parser_test failed");
                $finish;
            end
        end
    end

    initial begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        error_count  = 0;
        chars_sent   = 0;
        quiet_cycles = 0;
        tx_gap_on    = 1'b0;
        rx_stall_on  = 1'b0;
        hold_off_req = 1'b0;
        cfg_tolerant = 1'b0;
        cfg_dec_sep  = DEC_SEP_RST;
        cfg_thou_sep = THOU_SEP_RST;
        clear_literal();
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_literals();
        test_significand_limit();
        test_tolerant_mode();
        test_separator_codes();
        test_back_pressure();
        test_long_fraction();
        test_random_text();
        settle();
        if (error_count == 0) begin
            $display("decimal_number_text_parser_test passed");
        end else begin
            $display("decimal_number_text_parser_test failed");
        end
        $finish;
    end

endmodule
